// ===== sv/suvg_pkg.sv =====
// ----------------------------------------------------------------------------
// suvg_pkg: shared types and constants
// Constants of the splitmix64 generator and the command passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package suvg_pkg;

  localparam int unsigned MaxDim   = 64;
  localparam logic [63:0] GoldenGamma = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MixMulA     = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixMulB     = 64'h94D049BB133111EB;
  localparam logic [27:0] HalfQ27     = 28'h8000000;

  // command handed from front end to back end
  typedef struct packed {
    logic [63:0] start;
    logic [6:0]  count;
  } cmd_t;

endpackage

// ===== sv/seeded_unit_vector_generator_top.sv =====
// ----------------------------------------------------------------------------
// seeded_unit_vector_generator_top
// Splitmix64 unit vector generator with queue-style ports.
// ----------------------------------------------------------------------------
// Each seed yields vector_length components (1..64, 0 acts as 1) as saturated
// Q1.15 values, normalized by the integer square root of the sum of squares.
// Each draw is a counter add, two mixer multiplies on one 32x32 multiplier
// and a sign split. A seed runs a sum pass, the root and a normalize pass
// (draw, bit-serial divide, output), and waits while the result queue is
// full. Two seeds queue in front; two results queue at the output.
module seeded_unit_vector_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [63:0] seed_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic signed [15:0] component,
  output logic [5:0]  component_index,
  output logic        last
);

  logic [6:0] vector_length;
  logic cmd_valid, cmd_take;
  suvg_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  // hold the length register
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      vector_length <= cfg_data;
    end
  end

  suvg_front u_front (
    .clk, .rst, .push, .full, .seed_word, .vector_length,
    .cmd_valid, .cmd_take, .cmd
  );

  suvg_back u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd, .empty, .pop,
    .component, .component_index, .last
  );

  a_len_reset: assert property (@(posedge clk) rst |=> vector_length == 7'd64)
    else $error("length not reset");
  a_empty_reset: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

endmodule

// ===== sv/suvg_front.sv =====
// ----------------------------------------------------------------------------
// suvg_front: seed intake
// Replaces a zero seed, clamps the length and holds a two-entry command queue.
// ----------------------------------------------------------------------------
module suvg_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [63:0]       seed_word,
  input  logic [6:0]        vector_length,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output suvg_pkg::cmd_t    cmd
);

  suvg_pkg::cmd_t q [2];
  logic [1:0] fill;
  suvg_pkg::cmd_t in_cmd;
  logic do_push, do_pop;

  // classify the incoming seed
  always_comb begin
    in_cmd.start = (seed_word == 64'd0) ? suvg_pkg::GoldenGamma : seed_word;
    if (vector_length == 7'd0) begin
      in_cmd.count = 7'd1;
    end else if (vector_length > 7'(suvg_pkg::MaxDim)) begin
      in_cmd.count = 7'(suvg_pkg::MaxDim);
    end else begin
      in_cmd.count = vector_length;
    end
  end

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[0];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // shift-out queue; a push alongside a pop of the only entry lands in the head
  always_ff @(posedge clk) begin
    if (do_pop) begin
      if (do_push && fill == 2'd1) begin
        q[0] <= in_cmd;
      end else begin
        q[0] <= q[1];
      end
    end else if (do_push) begin
      q[fill[0]] <= in_cmd;
    end
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== sv/suvg_back.sv =====
// ----------------------------------------------------------------------------
// suvg_back: generator, square root and divider
// Runs both generator passes, the root and a restoring divider per component,
// and keeps a two-entry result queue.
// ----------------------------------------------------------------------------
module suvg_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_take,
  input  suvg_pkg::cmd_t  cmd,
  output logic            empty,
  input  logic            pop,
  output logic [15:0]     component,
  output logic [5:0]      component_index,
  output logic            last
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_MIX1, S_MIX2, S_SQ, S_ACC, S_ROOT, S_DIV, S_OUT
  } state_t;

  state_t      state;
  logic        pass2;
  logic [63:0] start, gen, z, sum;
  logic [6:0]  count, step;
  logic [27:0] mag;
  logic        neg;
  logic [55:0] sq;
  // mixer multiply, three 32x32 partial products per stage
  logic [1:0]  mph;
  logic [63:0] macc, mix_x, mix_k, mul_p;
  logic [31:0] mul_a, mul_b;
  // root
  logic [63:0] rx, rres, rbit;
  logic [31:0] norm;
  // divider
  logic [42:0] rem;
  logic [42:0] quo;
  logic [5:0]  dcnt;

  // result queue
  logic [22:0] oq [2];
  logic [1:0]  ofill;
  logic        opush, opop;
  logic [15:0] comp;
  logic [42:0] rem_sh;
  logic [16:0] qclip;
  logic [22:0] oword;

  assign empty = (ofill == 2'd0);
  assign {component, component_index, last} = oq[0];
  assign opop = pop && !empty;
  assign opush = (state == S_OUT) && (ofill != 2'd2);
  assign cmd_take = (state == S_IDLE);
  assign oword = {comp, step[5:0], (step + 7'd1 == count)};

  // select the partial product of the current mixer phase
  always_comb begin
    mix_x = (state == S_MIX1) ? (z ^ (z >> 30)) : (z ^ (z >> 27));
    mix_k = (state == S_MIX1) ? suvg_pkg::MixMulA : suvg_pkg::MixMulB;
    mul_a = (mph == 2'd2) ? mix_x[63:32] : mix_x[31:0];
    mul_b = (mph == 2'd1) ? mix_k[63:32] : mix_k[31:0];
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // saturate and sign the quotient
  always_comb begin
    qclip = 17'(quo);
    if (norm == 32'd0) begin
      comp = (step == 7'd0) ? 16'd32767 : 16'd0;
    end else if (neg) begin
      if (quo > 43'd32768) qclip = 17'd32768;
      comp = 16'(17'h10000 - qclip);
    end else begin
      if (quo > 43'd32767) qclip = 17'd32767;
      comp = qclip[15:0];
    end
    rem_sh = {rem[41:0], quo[42]};
  end

  always_ff @(posedge clk) begin
    if (opop) begin
      if (opush && ofill == 2'd1) begin
        oq[0] <= oword;
      end else begin
        oq[0] <= oq[1];
      end
    end else if (opush) begin
      oq[ofill[0]] <= oword;
    end
    if (rst) begin
      ofill <= 2'd0;
      state <= S_IDLE;
    end else begin
      ofill <= ofill + 2'(opush) - 2'(opop);
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            start <= cmd.start;
            gen   <= cmd.start;
            count <= cmd.count;
            step  <= 7'd0;
            sum   <= 64'd0;
            pass2 <= 1'b0;
            state <= S_ADD;
          end
        end
        // advance the counter and mix
        S_ADD: begin
          gen   <= gen + suvg_pkg::GoldenGamma;
          z     <= gen + suvg_pkg::GoldenGamma;
          mph   <= 2'd0;
          state <= S_MIX1;
        end
        // low 64 bits of the product: lo*lo, then both cross terms
        S_MIX1, S_MIX2: begin
          if (mph == 2'd2) begin
            z     <= macc + {mul_p[31:0], 32'd0};
            mph   <= 2'd0;
            state <= (state == S_MIX1) ? S_MIX2 : S_SQ;
          end else if (mph == 2'd1) begin
            macc <= macc + {mul_p[31:0], 32'd0};
            mph  <= 2'd2;
          end else begin
            macc <= mul_p;
            mph  <= 2'd1;
          end
        end
        // split into magnitude and sign
        S_SQ: begin
          if (((z ^ (z >> 31)) >> 36) >= 64'(suvg_pkg::HalfQ27)) begin
            mag <= 28'((z ^ (z >> 31)) >> 36) - suvg_pkg::HalfQ27;
            neg <= 1'b0;
          end else begin
            mag <= suvg_pkg::HalfQ27 - 28'((z ^ (z >> 31)) >> 36);
            neg <= 1'b1;
          end
          state <= pass2 ? S_DIV : S_ACC;
          rem   <= 43'd0;
          dcnt  <= 6'd44;
          quo   <= 43'd0;
          sq    <= 56'd0;
        end
        S_ACC: begin
          if (sq == 56'd0 && mag != 28'd0) begin
            sq <= 56'(mag) * 56'(mag);
          end else begin
            sum  <= sum + 64'(sq);
            step <= step + 7'd1;
            if (step + 7'd1 == count) begin
              rx    <= sum + 64'(sq);
              rres  <= 64'd0;
              rbit  <= 64'd1 << 62;
              state <= S_ROOT;
            end else begin
              state <= S_ADD;
            end
          end
        end
        // one root digit per cycle
        S_ROOT: begin
          if (rbit == 64'd0) begin
            norm  <= rres[31:0];
            gen   <= start;
            step  <= 7'd0;
            pass2 <= 1'b1;
            state <= S_ADD;
          end else begin
            if (rx >= rres + rbit) begin
              rx   <= rx - (rres + rbit);
              rres <= (rres >> 1) + rbit;
            end else begin
              rres <= rres >> 1;
            end
            rbit <= rbit >> 2;
          end
        end
        // load the dividend, then one quotient bit per cycle for all 43 bits
        S_DIV: begin
          if (dcnt == 6'd0 || norm == 32'd0) begin
            state <= S_OUT;
          end else begin
            if (dcnt == 6'd44) begin
              quo <= {mag, 15'd0};
              dcnt <= dcnt - 6'd1;
            end else begin
              dcnt <= dcnt - 6'd1;
              if (rem_sh >= 43'(norm)) begin
                rem <= rem_sh - 43'(norm);
                quo <= {quo[41:0], 1'b1};
              end else begin
                rem <= rem_sh;
                quo <= {quo[41:0], 1'b0};
              end
            end
          end
        end
        S_OUT: begin
          if (opush) begin
            step <= step + 7'd1;
            state <= (step + 7'd1 == count) ? S_IDLE : S_ADD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
